// File: src/frt_pkg.sv
package frt_pkg;

  localparam int TACH_W    = 8;
  localparam int CODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int FAN_IDX_W = 2;
  localparam int RPM_W     = 21;
  // A count shifted by the largest divisor code.
  localparam int DIVR_W    = TACH_W + (1 << CODE_W) - 1;
  localparam int STEP_W    = $clog2(RPM_W);

  localparam int FAN_COUNT_DEFAULT = 2;

  localparam logic [RPM_W-1:0]  RPM_NUMERATOR = RPM_W'(1350000);
  localparam logic [TACH_W-1:0] TACH_OVERFLOW = TACH_W'(8'hFF);
  localparam logic [TACH_W-1:0] TACH_ZERO     = '0;
  localparam logic [CODE_W-1:0] CODE_MAX      = CODE_W'(3);
  localparam logic [CODE_W-1:0] CODE_RESET    = CODE_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID   = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_NOFAN   = 2'd2,
    ST_ZERO    = 2'd3
  } frt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } frt_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } frt_div_stat_t;

endpackage

// File: src/frt_if.sv
interface frt_in_if;
  logic                         valid;
  logic                         ready;
  logic [frt_pkg::FAN_IDX_W-1:0] fan_index;
  logic [frt_pkg::TACH_W-1:0]    tach_count;

  modport source (output valid, fan_index, tach_count, input ready);
  modport sink   (input valid, fan_index, tach_count, output ready);
endinterface

interface frt_out_if;
  logic                         valid;
  logic                         ready;
  logic [frt_pkg::STATUS_W-1:0] status;
  logic [frt_pkg::RPM_W-1:0]    rpm;
  logic [frt_pkg::CODE_W-1:0]   divisor_code;

  modport source (output valid, status, rpm, divisor_code, input ready);
  modport sink   (input valid, status, rpm, divisor_code, output ready);
endinterface

// File: src/frt_divider.sv
module frt_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [frt_pkg::DIVR_W-1:0]    divisor,
  output logic [frt_pkg::RPM_W-1:0]     quotient,
  output frt_pkg::frt_div_stat_t        stat
);
  import frt_pkg::*;

  logic [DIVR_W-1:0] divr;
  logic [DIVR_W-1:0] rem;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;
  logic              fits;

  // Restoring division of the fixed numerator, one quotient bit a cycle,
  // most significant bit first.
  assign trial = {rem, RPM_NUMERATOR[step]};
  assign diff  = trial - {1'b0, divr};
  assign fits  = trial >= {1'b0, divr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divr     <= divisor;
      rem      <= '0;
      step     <= STEP_W'(RPM_W - 1);
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      quotient <= {quotient[RPM_W-2:0], fits};
      step     <= step - STEP_W'(1);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: src/fan_tach_rpm_autorange_unit.sv
// Fan tachometer to speed converter with automatic divisor range.
//
// Channel tach takes one word: a fan index and a raw period count. Channel
// speed returns exactly one word for each: a status, the speed in rpm and
// the fan's divisor code after the reading. Both use valid/ready.
//
// A valid reading is divided into 1350000 by a restoring divider that yields
// one quotient bit a cycle; the sequencer then loads the result into the
// output register. Overflow, zero and unknown-fan readings skip the divider
// and go from the sequencer's finish state to the output register. The block
// takes one word at a time; tach.ready is high only when the sequencer is
// idle.
//
// Results sit in an output register. While the receiver stalls, the block
// may accept and process the next word, then holds that result until the
// output register frees up.
//
// Reset clears the sequencer and the output register and sets every fan's
// divisor code to 1.
module fan_tach_rpm_autorange_unit #(
  parameter int FAN_COUNT = frt_pkg::FAN_COUNT_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  frt_in_if.sink    tach,
  frt_out_if.source speed
);
  import frt_pkg::*;

  localparam int IDX_W = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;
  localparam int EXT_W = IDX_W + FAN_IDX_W;

  frt_state_t state, state_next;

  logic [CODE_W-1:0] fan_div [FAN_COUNT];

  logic              accept;
  logic [EXT_W-1:0]  idx_ext;
  logic [IDX_W-1:0]  sel;
  logic              fan_ok;
  logic [CODE_W-1:0] code_cur;
  logic [CODE_W-1:0] code_inc;
  logic              is_over;
  logic              is_zero;
  logic              needs_div;
  logic              div_start;
  logic              fin_load;
  logic [DIVR_W-1:0] divisor;
  logic [RPM_W-1:0]  quotient;
  frt_div_stat_t     div_stat;

  frt_status_t       res_status;
  logic [CODE_W-1:0] res_code;

  logic              out_valid;
  frt_status_t       out_status;
  logic [RPM_W-1:0]  out_rpm;
  logic [CODE_W-1:0] out_code;

  assign accept   = tach.valid && tach.ready;
  assign idx_ext  = EXT_W'(tach.fan_index);
  assign sel      = idx_ext[IDX_W-1:0];
  assign fan_ok   = idx_ext < EXT_W'(FAN_COUNT);
  assign code_cur = fan_ok ? fan_div[sel] : '0;
  assign code_inc = (code_cur < CODE_MAX) ? code_cur + CODE_W'(1) : code_cur;
  assign is_over  = tach.tach_count == TACH_OVERFLOW;
  assign is_zero  = tach.tach_count == TACH_ZERO;
  assign needs_div = fan_ok && !is_over && !is_zero;
  assign divisor  = DIVR_W'(tach.tach_count) << code_cur;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = needs_div ? S_DIV : S_FIN;
      S_DIV:  if (div_stat.done) state_next = S_FIN;
      S_FIN:  if (!out_valid || speed.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    tach.ready = 1'b0;
    fin_load   = 1'b0;
    unique case (state)
      S_IDLE:  tach.ready = 1'b1;
      S_DIV:   ;
      S_FIN:   fin_load = !out_valid || speed.ready;
      default: ;
    endcase
  end

  assign div_start = accept && needs_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divisor code store; an overflow steps the fan's code up to its limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FAN_COUNT; i++) begin
        fan_div[i] <= CODE_RESET;
      end
    end else if (accept && fan_ok && is_over) begin
      fan_div[sel] <= code_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!fan_ok) begin
        res_status <= ST_NOFAN;
        res_code   <= '0;
      end else if (is_over) begin
        res_status <= ST_UNKNOWN;
        res_code   <= code_inc;
      end else if (is_zero) begin
        res_status <= ST_ZERO;
        res_code   <= code_cur;
      end else begin
        res_status <= ST_VALID;
        res_code   <= code_cur;
      end
    end
  end

  frt_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (speed.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_status <= res_status;
      out_rpm    <= (res_status == ST_VALID) ? quotient : '0;
      out_code   <= res_code;
    end
  end

  assign speed.valid        = out_valid;
  assign speed.status       = out_status;
  assign speed.rpm          = out_rpm;
  assign speed.divisor_code = out_code;

  a_div_alive: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on an idle divider");

  a_rpm_nonzero: assert property (@(posedge clk) disable iff (rst)
    fin_load && res_status == ST_VALID |-> quotient != '0)
    else $error("valid reading produced a zero speed");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> !tach.ready)
    else $error("word taken while the previous one is still in progress");

endmodule
